// ===== hdl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg: shared definitions for the Coulomb field summation core
// Constants, codes, the sequencer state type and the accumulator helpers.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // Default and largest usable charge store depth (slots are 8 bits wide).
    localparam int DEF_MAX_NODES  = 256;
    localparam int SLOT_DEPTH_MAX = 256;

    // Datapath widths.
    localparam int ACC_W = 58;
    localparam int NUM_W = 96;
    localparam int OUT_W = 48;
    localparam int RND_W = ACC_W - 7;

    // k * 1e-12 in Q32 volts * meters per picocoulomb.
    localparam logic [32:0] K_COEF = 33'd38601241;

    // Largest magnitude of a single field term (2^56).
    localparam logic [NUM_W-1:0] TERM_CAP = 96'h000000000100000000000000;

    // Accumulator and output limits.
    localparam logic signed [ACC_W-1:0] ACC_MAX = (58'sd1 <<< 55) - 58'sd1;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -(58'sd1 <<< 55);
    localparam logic signed [RND_W-1:0] OUT_MAX = (51'sd1 <<< 47) - 51'sd1;
    localparam logic signed [RND_W-1:0] OUT_MIN = -(51'sd1 <<< 47);

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXT_X = 2'd0;
    localparam logic [1:0] CFG_EXT_Y = 2'd1;
    localparam logic [1:0] CFG_EXT_Z = 2'd2;

    // Sequencer states.
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_EXT  = 13'b0000000000010,
        S_SCAN = 13'b0000000000100,
        S_DIFF = 13'b0000000001000,
        S_SQ   = 13'b0000000010000,
        S_SQRT = 13'b0000000100000,
        S_TQ   = 13'b0000001000000,
        S_DEN  = 13'b0000010000000,
        S_DIV  = 13'b0000100000000,
        S_POST = 13'b0001000000000,
        S_FNUM = 13'b0010000000000,
        S_NEXT = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } t_state;

    // Clip a widened accumulator sum to the accumulator range.
    function automatic logic signed [ACC_W-1:0] acc_clip(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] res;
        if (v > ACC_MAX) begin
            res = ACC_MAX;
        end else if (v < ACC_MIN) begin
            res = ACC_MIN;
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    // True when a widened accumulator sum lies outside the accumulator range.
    function automatic logic acc_over(input logic signed [ACC_W:0] v);
        return (v > ACC_MAX) || (v < ACC_MIN);
    endfunction

    // Round a Q8 accumulator to the nearest integer, ties upward.
    function automatic logic signed [RND_W-1:0] acc_round(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = (ACC_W+1)'(a) + 59'sd128;
        return t[ACC_W:8];
    endfunction

    // Clip a rounded value to the output range.
    function automatic logic signed [OUT_W-1:0] out_clip(input logic signed [RND_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > OUT_MAX) begin
            res = OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            res = OUT_MIN[OUT_W-1:0];
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

    // True when a rounded value lies outside the output range.
    function automatic logic out_over(input logic signed [RND_W-1:0] v);
        return (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

endpackage

// ===== hdl/coulomb_field_sum_core.sv =====
// ----------------------------------------------------------------------------
// coulomb_field_sum_core: potential and field from stored point charges
// Direct summation over a charge store with one shared multiplier, a
// bit-serial square root and a bit-serial divider under one sequencer.
// ----------------------------------------------------------------------------
// A load item gives no result. A query item first forms the external field,
// then walks all min(MAX_NODES, 256) slots: a slot that is absent or
// excluded is skipped, and each charge that is summed takes a 32-step
// square root and up to four 96-step divisions on the shared divider.
// Then the core rounds and hands over the result once the output register
// is free. The input channel stalls for the whole query.
// The output register lets a result wait while load items go on.

module coulomb_field_sum_core #(
    parameter int MAX_NODES = cfs_pkg::DEF_MAX_NODES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [7:0]           i_slot,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic signed [31:0]   i_charge_value,
    input  logic                 i_present,
    input  logic                 i_exclude_enable,
    input  logic [7:0]           i_exclude_slot,
    // Output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [47:0]   o_potential,
    output logic signed [47:0]   o_field_x,
    output logic signed [47:0]   o_field_y,
    output logic signed [47:0]   o_field_z,
    output logic                 o_too_close,
    output logic                 o_saturated,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic signed [31:0]   i_cfg_data
);

    localparam int DEPTH = (MAX_NODES < cfs_pkg::SLOT_DEPTH_MAX) ?
                           MAX_NODES : cfs_pkg::SLOT_DEPTH_MAX;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = cfs_pkg::ACC_W;
    localparam int NUM_W = cfs_pkg::NUM_W;

    // Charge store.
    logic signed [31:0] mem_x [DEPTH];
    logic signed [31:0] mem_y [DEPTH];
    logic signed [31:0] mem_z [DEPTH];
    logic signed [31:0] mem_q [DEPTH];
    logic [DEPTH-1:0]   r_present;
    logic signed [31:0] r_rd_x, r_rd_y, r_rd_z, r_rd_q;

    // Control.
    cfs_pkg::t_state r_state, n_state;
    logic [1:0]      r_step, n_step;
    logic [6:0]      r_cnt, n_cnt;
    logic [IW-1:0]   r_idx, n_idx;
    logic [1:0]      r_fj, n_fj;
    logic            r_div_fld, n_div_fld;
    logic            r_out_valid, n_out_valid;
    logic signed [31:0] r_ext [3];

    // Query payload.
    logic signed [31:0]      r_p [3], n_p [3];
    logic                    r_excl_en, n_excl_en;
    logic [7:0]              r_excl, n_excl;
    logic signed [ACC_W-1:0] r_acc_pot, n_acc_pot;
    logic signed [ACC_W-1:0] r_acc_f [3], n_acc_f [3];
    logic                    r_close, n_close;
    logic                    r_sat, n_sat;
    logic [31:0]             r_a [3], n_a [3];
    logic                    r_dneg [3], n_dneg [3];
    logic                    r_s, n_s;
    logic                    r_qneg, n_qneg;
    logic [31:0]             r_qmag, n_qmag;
    logic [63:0]             r_sum, n_sum;
    logic [63:0]             r_sq_v, n_sq_v;
    logic [63:0]             r_sq_r, n_sq_r;
    logic [63:0]             r_sq_bit, n_sq_bit;
    logic [31:0]             r_root, n_root;
    logic [56:0]             r_t1, n_t1;
    logic [63:0]             r_lo, n_lo;
    logic [NUM_W-1:0]        r_den, n_den;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [NUM_W-1:0]        r_rem, n_rem;
    logic [NUM_W-1:0]        r_dnm, n_dnm;
    logic signed [65:0]      r_prod;

    // Result register.
    logic signed [47:0] r_out_pot, n_out_pot;
    logic signed [47:0] r_out_f [3], n_out_f [3];
    logic               r_out_close, n_out_close;
    logic               r_out_sat, n_out_sat;

    // Handshakes and shared unit signals.
    logic               in_acc, out_acc, load_we, rd_en;
    logic [IW-1:0]      widx;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign load_we     = in_acc && (i_operation == cfs_pkg::OP_LOAD) &&
                         ({1'b0, i_slot} < 9'(DEPTH));
    assign widx        = i_slot[IW-1:0];
    assign o_in_stall  = (r_state != cfs_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_potential = r_out_pot;
    assign o_field_x   = r_out_f[0];
    assign o_field_y   = r_out_f[1];
    assign o_field_z   = r_out_f[2];
    assign o_too_close = r_out_close;
    assign o_saturated = r_out_sat;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            cfs_pkg::S_EXT: begin
                if (r_step != 2'd3) begin
                    mul_a = 33'(r_p[r_step]);
                    mul_b = 33'(r_ext[r_step]);
                end
            end
            cfs_pkg::S_SQ: begin
                if (r_step != 2'd3) begin
                    mul_a = {1'b0, r_a[r_step]};
                    mul_b = {1'b0, r_a[r_step]};
                end
            end
            cfs_pkg::S_TQ: begin
                mul_a = {1'b0, r_qmag};
                mul_b = cfs_pkg::K_COEF;
            end
            cfs_pkg::S_DEN: begin
                mul_a = {1'b0, r_root};
                mul_b = (r_step == 2'd0) ? {1'b0, r_sum[31:0]} : {1'b0, r_sum[63:32]};
            end
            cfs_pkg::S_FNUM: begin
                mul_a = (r_step == 2'd0) ? {1'b0, r_t1[31:0]} : {8'b0, r_t1[56:32]};
                mul_b = {1'b0, r_a[r_fj]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Sequencer and datapath next state.
    logic signed [ACC_W-1:0] prod_sh;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [32:0]      d [3];
    logic [32:0]             ad [3];
    logic                    big;
    logic [63:0]             sq_t;
    logic [63:0]             sq_rn;
    logic [NUM_W:0]          div_sh;
    logic [NUM_W-1:0]        full;
    logic                    cap_hit;
    logic [56:0]             mag;
    logic                    term_neg;
    logic signed [ACC_W:0]   term;
    logic                    scan_ok;
    logic                    fin_go;
    logic signed [cfs_pkg::RND_W-1:0] rnd [4];

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_fj        = r_fj;
        n_div_fld   = r_div_fld;
        n_p         = r_p;
        n_excl_en   = r_excl_en;
        n_excl      = r_excl;
        n_acc_pot   = r_acc_pot;
        n_acc_f     = r_acc_f;
        n_close     = r_close;
        n_sat       = r_sat;
        n_a         = r_a;
        n_dneg      = r_dneg;
        n_s         = r_s;
        n_qneg      = r_qneg;
        n_qmag      = r_qmag;
        n_sum       = r_sum;
        n_sq_v      = r_sq_v;
        n_sq_r      = r_sq_r;
        n_sq_bit    = r_sq_bit;
        n_root      = r_root;
        n_t1        = r_t1;
        n_lo        = r_lo;
        n_den       = r_den;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dnm       = r_dnm;
        n_out_pot   = r_out_pot;
        n_out_f     = r_out_f;
        n_out_close = r_out_close;
        n_out_sat   = r_out_sat;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        rd_en       = 1'b0;

        prod_sh  = r_prod[65:8];
        acc_sum  = (ACC_W+1)'(r_acc_pot) - (ACC_W+1)'(prod_sh);
        for (int j = 0; j < 3; j++) begin
            d[j]  = 33'(r_p[j]) - 33'((j == 0) ? r_rd_x : (j == 1) ? r_rd_y : r_rd_z);
            ad[j] = d[j][32] ? 33'(-d[j]) : 33'(d[j]);
        end
        big      = ad[0][32] | ad[0][31] | ad[1][32] | ad[1][31] | ad[2][32] | ad[2][31];
        sq_t     = r_sq_r + r_sq_bit;
        sq_rn    = (r_sq_v >= sq_t) ? ((r_sq_r >> 1) + r_sq_bit) : (r_sq_r >> 1);
        div_sh   = {r_rem, r_num[NUM_W-1]};
        full     = NUM_W'(r_lo) + (NUM_W'(r_prod[63:0]) << 32);
        cap_hit  = (r_num > cfs_pkg::TERM_CAP);
        mag      = cap_hit ? cfs_pkg::TERM_CAP[56:0] : r_num[56:0];
        term_neg = r_div_fld ? (r_qneg ^ r_dneg[r_fj]) : r_qneg;
        term     = term_neg ? -(ACC_W+1)'({2'b00, mag}) : (ACC_W+1)'({2'b00, mag});
        scan_ok  = r_present[r_idx] && !(r_excl_en && (8'(r_idx) == r_excl));
        fin_go   = !r_out_valid || !i_out_stall;
        rnd[0]   = cfs_pkg::acc_round(r_acc_pot);
        for (int j = 0; j < 3; j++) begin
            rnd[j+1] = cfs_pkg::acc_round(r_acc_f[j]);
        end

        unique case (r_state)
            // Wait for an item; a query latches its point and the field base.
            cfs_pkg::S_IDLE: begin
                if (in_acc && (i_operation == cfs_pkg::OP_QUERY)) begin
                    n_p[0]    = i_pos_x;
                    n_p[1]    = i_pos_y;
                    n_p[2]    = i_pos_z;
                    n_excl_en = i_exclude_enable;
                    n_excl    = i_exclude_slot;
                    for (int j = 0; j < 3; j++) begin
                        n_acc_f[j] = ACC_W'(r_ext[j]) <<< 8;
                    end
                    n_close = 1'b0;
                    n_sat   = 1'b0;
                    n_step  = 2'd0;
                    n_idx   = '0;
                    n_state = cfs_pkg::S_EXT;
                end
            end
            // External potential: minus the sum of the floored products.
            cfs_pkg::S_EXT: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_acc_pot = -prod_sh;
                end else if (r_step == 2'd2) begin
                    n_acc_pot = acc_sum[ACC_W-1:0];
                end else if (r_step == 2'd3) begin
                    n_acc_pot = cfs_pkg::acc_clip(acc_sum);
                    n_sat     = r_sat | cfs_pkg::acc_over(acc_sum);
                    n_state   = cfs_pkg::S_SCAN;
                end
            end
            // Check the slot and start the store read.
            cfs_pkg::S_SCAN: begin
                if (scan_ok) begin
                    rd_en   = 1'b1;
                    n_state = cfs_pkg::S_DIFF;
                end else begin
                    n_state = cfs_pkg::S_NEXT;
                end
            end
            // Coordinate differences, magnitudes and the range shift.
            cfs_pkg::S_DIFF: begin
                for (int j = 0; j < 3; j++) begin
                    n_a[j]    = big ? ad[j][32:1] : ad[j][31:0];
                    n_dneg[j] = d[j][32];
                end
                n_s    = big;
                n_qneg = r_rd_q[31];
                n_qmag = r_rd_q[31] ? 32'(-33'(r_rd_q)) : 32'(r_rd_q);
                n_sum  = '0;
                n_step = 2'd0;
                if ((ad[0] == '0) && (ad[1] == '0) && (ad[2] == '0)) begin
                    n_close = 1'b1;
                    n_state = cfs_pkg::S_NEXT;
                end else begin
                    n_state = cfs_pkg::S_SQ;
                end
            end
            // Sum of squares through the multiplier.
            cfs_pkg::S_SQ: begin
                n_step = r_step + 2'd1;
                if (r_step != 2'd0) begin
                    n_sum = r_sum + r_prod[63:0];
                end
                if (r_step == 2'd3) begin
                    n_sq_v   = r_sum + r_prod[63:0];
                    n_sq_r   = '0;
                    n_sq_bit = 64'h4000000000000000;
                    n_cnt    = '0;
                    n_state  = cfs_pkg::S_SQRT;
                end
            end
            // Integer square root, one result bit per cycle.
            cfs_pkg::S_SQRT: begin
                if (r_sq_v >= sq_t) begin
                    n_sq_v = r_sq_v - sq_t;
                end
                n_sq_r   = sq_rn;
                n_sq_bit = r_sq_bit >> 2;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    n_root  = sq_rn[31:0];
                    n_step  = 2'd0;
                    n_state = cfs_pkg::S_TQ;
                end
            end
            // Scaled charge magnitude.
            cfs_pkg::S_TQ: begin
                if (r_step == 2'd0) begin
                    n_step = 2'd1;
                end else begin
                    n_t1   = r_prod[56:0];
                    n_step = 2'd0;
                    if ((r_qmag == '0) || (r_root == '0)) begin
                        n_state = cfs_pkg::S_NEXT;
                    end else begin
                        n_state = cfs_pkg::S_DEN;
                    end
                end
            end
            // Cube of the distance as root times sum, then the potential division.
            cfs_pkg::S_DEN: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_lo = r_prod[63:0];
                end else if (r_step == 2'd2) begin
                    n_den     = full;
                    n_num     = NUM_W'(r_t1);
                    n_dnm     = r_s ? (NUM_W'(r_root) << 9) : (NUM_W'(r_root) << 8);
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_div_fld = 1'b0;
                    n_state   = cfs_pkg::S_DIV;
                end
            end
            // Restoring division, one quotient bit per cycle.
            cfs_pkg::S_DIV: begin
                if (div_sh >= {1'b0, r_dnm}) begin
                    n_rem = NUM_W'(div_sh - {1'b0, r_dnm});
                    n_num = {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = div_sh[NUM_W-1:0];
                    n_num = {r_num[NUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(NUM_W-1)) begin
                    n_state = cfs_pkg::S_POST;
                end
            end
            // Add the signed term to its accumulator.
            cfs_pkg::S_POST: begin
                n_sat  = r_sat | cap_hit;
                n_step = 2'd0;
                if (!r_div_fld) begin
                    acc_sum   = (ACC_W+1)'(r_acc_pot) + term;
                    n_acc_pot = cfs_pkg::acc_clip(acc_sum);
                    n_sat     = r_sat | cap_hit | cfs_pkg::acc_over(acc_sum);
                    n_fj      = 2'd0;
                    n_state   = cfs_pkg::S_FNUM;
                end else begin
                    acc_sum        = (ACC_W+1)'(r_acc_f[r_fj]) + term;
                    n_acc_f[r_fj]  = cfs_pkg::acc_clip(acc_sum);
                    n_sat          = r_sat | cap_hit | cfs_pkg::acc_over(acc_sum);
                    if (r_fj == 2'd2) begin
                        n_state = cfs_pkg::S_NEXT;
                    end else begin
                        n_fj    = r_fj + 2'd1;
                        n_state = cfs_pkg::S_FNUM;
                    end
                end
            end
            // Field numerator for one axis, then its division.
            cfs_pkg::S_FNUM: begin
                if (r_step == 2'd0) begin
                    if (r_a[r_fj] == '0) begin
                        if (r_fj == 2'd2) begin
                            n_state = cfs_pkg::S_NEXT;
                        end else begin
                            n_fj = r_fj + 2'd1;
                        end
                    end else begin
                        n_step = 2'd1;
                    end
                end else if (r_step == 2'd1) begin
                    n_lo   = r_prod[63:0];
                    n_step = 2'd2;
                end else begin
                    n_num     = r_s ? (full << 6) : (full << 8);
                    n_dnm     = r_den;
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_div_fld = 1'b1;
                    n_step    = 2'd0;
                    n_state   = cfs_pkg::S_DIV;
                end
            end
            // Advance to the next slot.
            cfs_pkg::S_NEXT: begin
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_state = cfs_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = cfs_pkg::S_SCAN;
                end
            end
            // Round, clip and load the result register once it is free.
            cfs_pkg::S_FIN: begin
                if (fin_go) begin
                    n_out_pot = cfs_pkg::out_clip(rnd[0]);
                    for (int j = 0; j < 3; j++) begin
                        n_out_f[j] = cfs_pkg::out_clip(rnd[j+1]);
                    end
                    n_out_close = r_close;
                    n_out_sat   = r_sat | cfs_pkg::out_over(rnd[0]) |
                                  cfs_pkg::out_over(rnd[1]) | cfs_pkg::out_over(rnd[2]) |
                                  cfs_pkg::out_over(rnd[3]);
                    n_out_valid = 1'b1;
                    n_state     = cfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_present   <= '0;
            for (int j = 0; j < 3; j++) begin
                r_ext[j] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (load_we) begin
                r_present[widx] <= i_present;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == cfs_pkg::CFG_EXT_X) begin
                    r_ext[0] <= i_cfg_data;
                end else if (i_cfg_index == cfs_pkg::CFG_EXT_Y) begin
                    r_ext[1] <= i_cfg_data;
                end else if (i_cfg_index == cfs_pkg::CFG_EXT_Z) begin
                    r_ext[2] <= i_cfg_data;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_fj        <= n_fj;
        r_div_fld   <= n_div_fld;
        r_p         <= n_p;
        r_excl_en   <= n_excl_en;
        r_excl      <= n_excl;
        r_acc_pot   <= n_acc_pot;
        r_acc_f     <= n_acc_f;
        r_close     <= n_close;
        r_sat       <= n_sat;
        r_a         <= n_a;
        r_dneg      <= n_dneg;
        r_s         <= n_s;
        r_qneg      <= n_qneg;
        r_qmag      <= n_qmag;
        r_sum       <= n_sum;
        r_sq_v      <= n_sq_v;
        r_sq_r      <= n_sq_r;
        r_sq_bit    <= n_sq_bit;
        r_root      <= n_root;
        r_t1        <= n_t1;
        r_lo        <= n_lo;
        r_den       <= n_den;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_dnm       <= n_dnm;
        r_prod      <= mul_p;
        r_out_pot   <= n_out_pot;
        r_out_f     <= n_out_f;
        r_out_close <= n_out_close;
        r_out_sat   <= n_out_sat;
    end

    // Charge store write and registered read.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_x[widx] <= i_pos_x;
            mem_y[widx] <= i_pos_y;
            mem_z[widx] <= i_pos_z;
            mem_q[widx] <= i_charge_value;
        end
        if (rd_en) begin
            r_rd_x <= mem_x[r_idx];
            r_rd_y <= mem_y[r_idx];
            r_rd_z <= mem_z[r_idx];
            r_rd_q <= mem_q[r_idx];
        end
    end

    // The partial remainder always stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfs_pkg::S_DIV) |-> (r_rem < r_dnm))
        else $error("divider remainder not below divisor");

    // The square root trial bit is a single bit for every step.
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfs_pkg::S_SQRT) |-> $onehot(r_sq_bit))
        else $error("square root trial bit lost");

    // A load transfer leaves the sequencer idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == cfs_pkg::OP_LOAD)) |=> (r_state == cfs_pkg::S_IDLE))
        else $error("load item left the sequencer busy");

    // A result appears only from the final step of a query.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == cfs_pkg::S_FIN))
        else $error("result raised outside the final step");

endmodule
